// ----- sv/rbws_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the ring buffer window statistics block.
// No dependencies; used by the channel interfaces, the divider and the top level.
package rbws_pkg;

   localparam int DEPTH_DEFAULT = 1024;

   localparam int SAMPLE_W = 16;
   localparam int WIN_W    = 11;
   localparam int COUNT_W  = 10;
   // window sum: up to 2047 samples of 16 bits
   localparam int SUM_W    = SAMPLE_W + WIN_W;
   localparam int STEP_W   = $clog2(SUM_W + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_WALK = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

// ----- sv/rbws_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response transactions.
// Depends on rbws_pkg for field widths.
interface rbws_req_if;
   import rbws_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic [WIN_W-1:0]           window_len;

   modport source (output valid, sample, window_len, input ready);
   modport sink   (input valid, sample, window_len, output ready);
endinterface

interface rbws_rsp_if;
   import rbws_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] average;
   logic signed [SAMPLE_W-1:0] minimum;
   logic signed [SAMPLE_W-1:0] maximum;
   logic [COUNT_W-1:0]         used_count;
   logic                       window_error;

   modport source (output valid, average, minimum, maximum, used_count, window_error,
                   input ready);
   modport sink   (input valid, average, minimum, maximum, used_count, window_error,
                   output ready);
endinterface

// ----- sv/ring_buffer_window_stats.sv -----
`timescale 1ns / 1ps
// Ring buffer window statistics: top level with the sample memory and walk control.
// Depends on rbws_pkg, rbws_req_if / rbws_rsp_if and rbws_div.
//
// Usage:
//   req_bus carries one sample and a window length per transaction. The sample is
//   appended to a DEPTH-entry ring memory (holding at most DEPTH-1 samples), then
//   the newest min(window_len, stored) samples are walked back from the newest.
//   rsp_bus returns minimum, maximum, truncated average, the count used and an
//   error flag (window_len zero or above DEPTH: flag set, statistics zero).
//   For a valid window, acceptance leads through the walk (one memory read per
//   cycle), the serial divider and the handoff to the output register before
//   rsp_bus.valid; an error transaction skips the walk and divider and goes
//   straight to the handoff. One transaction is in flight at a time;
//   req_bus.ready is high only while idle.
//   Results sit in an output register: the next request is accepted while a
//   result still waits, and a stalled rsp_bus holds only the next result back.
//   Reset clears the write and oldest indexes and all control; memory contents
//   are not cleared and need no clearing pass since only written slots are read.
module ring_buffer_window_stats #(
   parameter int DEPTH = rbws_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rbws_req_if.sink    req_bus,
   rbws_rsp_if.source  rsp_bus
);
   import rbws_pkg::*;

   localparam int          AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [31:0] DEPTH_U = 32'(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   logic signed [SAMPLE_W-1:0] sample_mem [DEPTH];

   state_type                  state_ff;
   logic [AW-1:0]              wr_ff;
   logic [AW-1:0]              oldest_ff;
   logic [AW-1:0]              idx_ff;
   logic [WIN_W-1:0]           remain_ff;
   logic                       issue_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       rd_vld_ff;
   logic                       rd_last_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SAMPLE_W-1:0] min_ff;
   logic signed [SAMPLE_W-1:0] max_ff;
   logic [WIN_W-1:0]           cnt_ff;
   logic                       err_ff;
   logic                       div_start_ff;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_avg_ff;
   logic signed [SAMPLE_W-1:0] rsp_min_ff;
   logic signed [SAMPLE_W-1:0] rsp_max_ff;
   logic [COUNT_W-1:0]         rsp_cnt_ff;
   logic                       rsp_err_ff;

   logic                       accept;
   logic                       win_bad;
   logic [AW-1:0]              wr_in;
   logic                       issue_last;
   logic                       rsp_load;
   logic                       div_done;
   logic signed [SAMPLE_W-1:0] div_q;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign win_bad       = (req_bus.window_len == '0) ||
                          ({21'b0, req_bus.window_len} > DEPTH_U);
   assign wr_in         = (wr_ff == LAST_IDX) ? '0 : wr_ff + 1'b1;
   assign issue_last    = (remain_ff == WIN_W'(1)) || (idx_ff == oldest_ff);
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // sample memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_mem[wr_ff] <= req_bus.sample;
      end
      rd_data_ff <= sample_mem[idx_ff];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ff        <= '0;
         oldest_ff    <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         rd_vld_ff    <= (state_ff == ST_WALK) && issue_ff;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  wr_ff <= wr_in;
                  if (wr_in == oldest_ff) begin
                     oldest_ff <= (oldest_ff == LAST_IDX) ? '0 : oldest_ff + 1'b1;
                  end
                  issue_ff <= !win_bad;
                  state_ff <= win_bad ? ST_DONE : ST_WALK;
               end
            end
            ST_WALK: begin
               if (issue_ff && issue_last) begin
                  issue_ff <= 1'b0;
               end
               if (rd_vld_ff && rd_last_ff) begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // walk datapath: issue addresses newest first, accumulate returning samples
   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff    <= wr_ff;
         remain_ff <= req_bus.window_len;
         err_ff    <= win_bad;
         sum_ff    <= '0;
         cnt_ff    <= '0;
         min_ff    <= {1'b0, {(SAMPLE_W-1){1'b1}}};
         max_ff    <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         if (state_ff == ST_WALK && issue_ff) begin
            idx_ff     <= (idx_ff == '0) ? LAST_IDX : idx_ff - 1'b1;
            remain_ff  <= remain_ff - 1'b1;
            rd_last_ff <= issue_last;
         end
         if (rd_vld_ff) begin
            sum_ff <= sum_ff + {{(SUM_W-SAMPLE_W){rd_data_ff[SAMPLE_W-1]}}, rd_data_ff};
            cnt_ff <= cnt_ff + 1'b1;
            if (rd_data_ff < min_ff) min_ff <= rd_data_ff;
            if (rd_data_ff > max_ff) max_ff <= rd_data_ff;
         end
      end
   end

   rbws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_err_ff <= err_ff;
         rsp_avg_ff <= err_ff ? '0 : div_q;
         rsp_min_ff <= err_ff ? '0 : min_ff;
         rsp_max_ff <= err_ff ? '0 : max_ff;
         rsp_cnt_ff <= err_ff ? '0 : cnt_ff[COUNT_W-1:0];
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.average      = rsp_avg_ff;
   assign rsp_bus.minimum      = rsp_min_ff;
   assign rsp_bus.maximum      = rsp_max_ff;
   assign rsp_bus.used_count   = rsp_cnt_ff;
   assign rsp_bus.window_error = rsp_err_ff;

endmodule

// ----- sv/rbws_div.sv -----
`timescale 1ns / 1ps
// Serial signed divider: window sum by sample count, truncated toward zero.
// One quotient bit per cycle on magnitudes (restoring). Depends on rbws_pkg.
module rbws_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [rbws_pkg::SUM_W-1:0]  dividend,
   input  logic [rbws_pkg::WIN_W-1:0]         divisor,
   output logic                               done,
   output logic signed [rbws_pkg::SAMPLE_W-1:0] quotient
);
   import rbws_pkg::*;

   logic                  busy_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [WIN_W-1:0]      rem_ff;
   logic [SUM_W-1:0]      quo_ff;
   logic [WIN_W-1:0]      dsr_ff;
   logic                  neg_ff;
   logic                  done_ff;
   logic [SAMPLE_W-1:0]   q_ff;

   logic [WIN_W:0]        trial;
   logic                  fits;
   logic [WIN_W:0]        diff;
   logic [SUM_W-1:0]      quo_in;
   logic [SUM_W-1:0]      mag;
   logic [SUM_W-1:0]      q_signed;

   assign mag    = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
   assign trial  = {rem_ff, quo_ff[SUM_W-1]};
   assign fits   = trial >= {1'b0, dsr_ff};
   assign diff   = trial - {1'b0, dsr_ff};
   assign quo_in = {quo_ff[SUM_W-2:0], fits};
   assign q_signed = neg_ff ? SUM_W'(-quo_in) : quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(SUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= '0;
         rem_ff  <= '0;
         quo_ff  <= mag;
         dsr_ff  <= divisor;
         neg_ff  <= dividend[SUM_W-1];
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         rem_ff  <= fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
         quo_ff  <= quo_in;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            q_ff <= q_signed[SAMPLE_W-1:0];
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench for ring_buffer_window_stats: bursts of samples with mixed window lengths,
// a running prediction of the window statistics and an in-order check of each response.
// Depends on rbws_pkg, rbws_req_if / rbws_rsp_if and the block itself.
module tb;
   import rbws_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int FILL_ITEMS   = 200;
   localparam int RANDOM_ITEMS = 320;
   localparam int HOLD_CYCLES  = 3000;
   localparam int CYCLE_LIMIT  = 5_000_000;

   typedef struct {
      logic signed [SAMPLE_W-1:0] average;
      logic signed [SAMPLE_W-1:0] minimum;
      logic signed [SAMPLE_W-1:0] maximum;
      logic [COUNT_W-1:0]         used_count;
      logic                       window_error;
   } window_stats_type;

   class window_stats_tracker;
      logic signed [SAMPLE_W-1:0] samples [DEPTH];
      int unsigned                write_pos;
      int unsigned                oldest_pos;
      window_stats_type           pending_stats[$];
      int                         mismatch_count;

      function new();
         write_pos      = 0;
         oldest_pos     = 0;
         mismatch_count = 0;
      endfunction

      // append the sample, then summarize the newest window_len stored samples
      function void note_sample(logic signed [SAMPLE_W-1:0] sample,
                                logic [WIN_W-1:0] window_len);
         window_stats_type stats;
         int unsigned      pos;
         int unsigned      left;
         int unsigned      used;
         longint           total;
         samples[write_pos] = sample;
         write_pos = (write_pos + 1) % DEPTH;
         if (write_pos == oldest_pos) begin
            oldest_pos = (oldest_pos + 1) % DEPTH;
         end
         stats.average      = '0;
         stats.minimum      = '0;
         stats.maximum      = '0;
         stats.used_count   = '0;
         stats.window_error = 1'b0;
         if (window_len == 0 || window_len > DEPTH) begin
            stats.window_error = 1'b1;
         end else begin
            pos   = write_pos;
            left  = window_len;
            used  = 0;
            total = 0;
            stats.minimum = sample;
            stats.maximum = sample;
            while (left > 0) begin
               pos = (pos == 0) ? DEPTH - 1 : pos - 1;
               if (samples[pos] < stats.minimum) stats.minimum = samples[pos];
               if (samples[pos] > stats.maximum) stats.maximum = samples[pos];
               total += samples[pos];
               used++;
               if (pos == oldest_pos) break;
               left--;
            end
            // longint division truncates toward zero
            stats.average    = SAMPLE_W'(total / longint'(used));
            stats.used_count = COUNT_W'(used);
         end
         pending_stats.push_back(stats);
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_stats(window_stats_type got);
         window_stats_type want;
         if (pending_stats.size() == 0) begin
            $display("%0t: unexpected response avg %0d min %0d max %0d count %0d err %0b",
                     $time, got.average, got.minimum, got.maximum, got.used_count,
                     got.window_error);
            mismatch_count++;
            return;
         end
         want = pending_stats.pop_front();
         compare_field("average", want.average, got.average);
         compare_field("minimum", want.minimum, got.minimum);
         compare_field("maximum", want.maximum, got.maximum);
         compare_field("used_count", want.used_count, got.used_count);
         compare_field("window_error", want.window_error, got.window_error);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic hold_rsp;
   int   accepted_count;
   int   burst_left;

   window_stats_tracker tracker = new();

   rbws_req_if req_bus ();
   rbws_rsp_if rsp_bus ();

   ring_buffer_window_stats #(.DEPTH(DEPTH)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)  return 16'sh7FFF;
      if (pick < 8)  return 16'sh8000;
      if (pick < 11) return 16'sh0000;
      if (pick < 14) return 16'shFFFF;
      return SAMPLE_W'($urandom);
   endfunction

   task automatic send_item(input logic signed [SAMPLE_W-1:0] sample,
                            input logic [WIN_W-1:0] window_len);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 60)) @(posedge clock);
         else repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 20);
      end
      req_bus.valid      <= 1'b1;
      req_bus.sample     <= sample;
      req_bus.window_len <= window_len;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_sample(sample, window_len);
      accepted_count++;
      burst_left--;
   endtask

   // response side: checks each transaction and stalls on its own pattern
   initial begin : rsp_side
      window_stats_type got;
      int               mode;
      int               mode_left;
      int               phase;
      logic             ready_next;
      mode      = 0;
      mode_left = 0;
      phase     = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.average      = rsp_bus.average;
            got.minimum      = rsp_bus.minimum;
            got.maximum      = rsp_bus.maximum;
            got.used_count   = rsp_bus.used_count;
            got.window_error = rsp_bus.window_error;
            tracker.check_stats(got);
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         phase++;
         case (mode)
            0: ready_next = 1'b1;
            1: ready_next = 1'($urandom_range(0, 1));
            2: ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = (phase % 3 != 0);
         endcase
         rsp_bus.ready <= ready_next && !hold_rsp;
      end
   end

   // long receiver hold-off so the block backs up and drops req ready
   initial begin : long_hold
      int held;
      hold_rsp = 1'b0;
      held     = 0;
      while (accepted_count < 60) @(posedge clock);
      hold_rsp <= 1'b1;
      while (held < HOLD_CYCLES) begin
         @(posedge clock);
         held++;
      end
      hold_rsp <= 1'b0;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int               i;
      int unsigned      pick;
      logic [WIN_W-1:0] window_len;
      accepted_count = 0;
      burst_left     = 0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.sample     <= '0;
      req_bus.window_len <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, truncation at the oldest sample, error windows
      send_item(16'sh7FFF, 11'd1);
      send_item(16'sh8000, 11'd5);
      send_item(-16'sd3, 11'd2);
      send_item(16'sh0000, 11'd0);
      send_item(16'sd1, 11'd1025);
      send_item(16'shFFFF, 11'd2047);
      send_item(16'sd12345, 11'd1024);
      send_item(16'sh8000, 11'd3);
      send_item(16'sh7FFF, 11'd8);
      send_item(-16'sd5, 11'd2);
      send_item(-16'sd7, 11'd3);
      send_item(16'sd0, 11'd1);
      send_item(16'shFFFF, 11'd1);
      send_item(16'sd1, 11'd2);
      send_item(-16'sd2, 11'd1023);
      send_item(16'sh7FFF, 11'h555);
      send_item(16'sh8000, 11'h2AA);
      send_item(16'sh5555, 11'd4);
      send_item(16'shAAAA, 11'd6);

      // mostly short windows while the store fills
      for (i = 0; i < FILL_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 2)       window_len = 11'd1024;
         else if (pick < 14) window_len = 11'd0;
         else if (pick < 25) window_len = WIN_W'($urandom_range(1025, 2047));
         else if (pick < 85) window_len = WIN_W'($urandom_range(1, 4));
         else                window_len = WIN_W'($urandom_range(5, 64));
         send_item(pick_sample(), window_len);
      end

      // windows reaching the oldest sample, then a random mix
      send_item(pick_sample(), 11'd1024);
      send_item(pick_sample(), 11'd1023);
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)       window_len = WIN_W'($urandom_range(1000, 1024));
         else if (pick < 18) window_len = WIN_W'($urandom_range(65, 600));
         else if (pick < 21) window_len = 11'd0;
         else if (pick < 28) window_len = WIN_W'($urandom_range(1025, 2047));
         else                window_len = WIN_W'($urandom_range(1, 64));
         send_item(pick_sample(), window_len);
      end

      req_bus.valid <= 1'b0;
      while (tracker.pending_stats.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (tracker.mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
